// ===== hdl/point_angle_atan2_degrees_core_macros.svh =====
// Assertion macros for the atan2 core. They use the clk and rst_n of the module that
// includes this header.
`ifndef POINT_ANGLE_ATAN2_DEGREES_CORE_MACROS_SVH
`define POINT_ANGLE_ATAN2_DEGREES_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define PAA_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define PAA_ASSERT_AFTER(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("assertion failed");

`else

`define PAA_ASSERT_IMPLIES(lbl, ante, cons)

`define PAA_ASSERT_AFTER(lbl, ante, dly, cons)

`endif

`endif

// ===== hdl/paa_pkg.sv =====
package paa_pkg;

  localparam int COORD_BITS      = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int HALF_TURN_DEG   = 180;
  localparam int OUT_BITS        = 9 + ANGLE_FRAC_BITS;

  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS + 1;
  localparam int NORM_TOP   = 59;
  localparam int SHIFT_BITS = $clog2(NORM_TOP + 1);
  localparam int DATA_BITS  = NORM_TOP + 4;

  localparam int CORDIC_STEPS = 30;
  localparam int ANG_BITS     = 33;
  localparam int THETA_BITS   = 31;
  localparam logic [THETA_BITS-1:0] QUARTER_TURN = THETA_BITS'(64'd1 << 30);

  localparam int SCALE        = 2 * HALF_TURN_DEG * (2 ** ANGLE_FRAC_BITS);
  localparam int SCALE_BITS   = $clog2(SCALE + 1);
  localparam int PROD_BITS    = THETA_BITS + SCALE_BITS;
  localparam int ROUND_SHIFT  = 32;
  localparam int DEG_MAG_BITS = PROD_BITS - ROUND_SHIFT;

  // pipeline depth: diff, msb search, shift, CORDIC steps, scale, round/mirror
  localparam int LATENCY = 3 + CORDIC_STEPS + 2;

  // atan(2^-i), full turn = 2^32
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001
  };

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic ax_zero;
    logic ay_zero;
  } paa_flags_t;

endpackage

// ===== hdl/paa_cordic.sv =====
module paa_cordic
  import paa_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        valid_i,
  input  paa_flags_t                  flags_i,
  input  logic signed [DATA_BITS-1:0] x_i,
  input  logic signed [DATA_BITS-1:0] y_i,
  output logic                        valid_o,
  output paa_flags_t                  flags_o,
  output logic signed [ANG_BITS-1:0]  z_o
);

  logic                        v_r [CORDIC_STEPS];
  paa_flags_t                  f_r [CORDIC_STEPS];
  logic signed [DATA_BITS-1:0] x_r [CORDIC_STEPS];
  logic signed [DATA_BITS-1:0] y_r [CORDIC_STEPS];
  logic signed [ANG_BITS-1:0]  z_r [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    localparam logic signed [ANG_BITS-1:0] STEP_ANG = ANG_BITS'(ATAN_TAB[k]);

    logic                        v_in;
    paa_flags_t                  f_in;
    logic signed [DATA_BITS-1:0] x_in, y_in, xs, ys, x_nxt, y_nxt;
    logic signed [ANG_BITS-1:0]  z_in, z_nxt;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign f_in = flags_i;
      assign x_in = x_i;
      assign y_in = y_i;
      assign z_in = '0;
    end else begin : g_rest
      assign v_in = v_r[k-1];
      assign f_in = f_r[k-1];
      assign x_in = x_r[k-1];
      assign y_in = y_r[k-1];
      assign z_in = z_r[k-1];
    end

    assign xs = x_in >>> k;
    assign ys = y_in >>> k;

    always_comb begin
      if (!y_in[DATA_BITS-1]) begin
        x_nxt = x_in + ys;
        y_nxt = y_in - xs;
        z_nxt = z_in + STEP_ANG;
      end else begin
        x_nxt = x_in - ys;
        y_nxt = y_in + xs;
        z_nxt = z_in - STEP_ANG;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
      f_r[k] <= f_in;
      x_r[k] <= x_nxt;
      y_r[k] <= y_nxt;
      z_r[k] <= z_nxt;
    end
  end

  assign valid_o = v_r[CORDIC_STEPS-1];
  assign flags_o = f_r[CORDIC_STEPS-1];
  assign z_o     = z_r[CORDIC_STEPS-1];

endmodule

// ===== hdl/point_angle_atan2_degrees_core.sv =====
// Direction from one point to another as atan2(dy, dx) in degrees.
//
// Input: pulse start with in_from_x/in_from_y/in_to_x/in_to_y (signed 16 bit).
// A beat is taken on every edge where start is high and busy is low; busy
// stays low, so a new beat may enter on every clock.
// Output: out_valid is high for one cycle with out_angle_deg, signed, 8
// fraction bits, in -180..+180. Equal points give 0, the negative x axis +180.
// The pipeline has 3 front-end stages, 30 CORDIC stages and 2 scaling
// stages; throughput is one beat per cycle, set by the fully unrolled CORDIC
// pipeline with one micro-rotation per stage.
// Results leave in input order, one per beat. The receiver cannot stall;
// out_valid is a one-cycle strobe.
// Synchronous reset (rst_n low) clears all valid bits; beats in flight are
// dropped and no result appears until new beats have passed the pipeline.
`include "point_angle_atan2_degrees_core_macros.svh"

module point_angle_atan2_degrees_core
  import paa_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [COORD_BITS-1:0] in_from_x,
  input  logic signed [COORD_BITS-1:0] in_from_y,
  input  logic signed [COORD_BITS-1:0] in_to_x,
  input  logic signed [COORD_BITS-1:0] in_to_y,
  output logic                       out_valid,
  output logic signed [OUT_BITS-1:0] out_angle_deg
);

  localparam logic signed [OUT_BITS-1:0] HALF_TURN_FX =
    OUT_BITS'(HALF_TURN_DEG * (2 ** ANGLE_FRAC_BITS));
  localparam logic [SCALE_BITS-1:0] SCALE_V = SCALE_BITS'(SCALE);
  localparam logic [PROD_BITS-1:0]  ROUND_V = PROD_BITS'(64'd1 << (ROUND_SHIFT - 1));

  logic in_accept;

  assign busy      = 1'b0;
  assign in_accept = start && !busy;

  // stage 1: differences and magnitudes
  logic signed [DIFF_BITS-1:0] dx, dy;
  logic        [MAG_BITS-1:0]  ax_nxt, ay_nxt;
  paa_flags_t                  s1_flags_nxt;

  logic                s1_valid_r;
  paa_flags_t          s1_flags_r;
  logic [MAG_BITS-1:0] s1_ax_r, s1_ay_r;

  always_comb begin
    dx = DIFF_BITS'(in_to_x) - DIFF_BITS'(in_from_x);
    dy = DIFF_BITS'(in_to_y) - DIFF_BITS'(in_from_y);
    ax_nxt = dx[DIFF_BITS-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
    ay_nxt = dy[DIFF_BITS-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
    s1_flags_nxt.neg_x   = dx[DIFF_BITS-1];
    s1_flags_nxt.neg_y   = dy[DIFF_BITS-1];
    s1_flags_nxt.ax_zero = (dx == '0);
    s1_flags_nxt.ay_zero = (dy == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
    s1_flags_r <= s1_flags_nxt;
    s1_ax_r    <= ax_nxt;
    s1_ay_r    <= ay_nxt;
  end

  // stage 2: leading one search for normalization
  logic [MAG_BITS-1:0]   mag_or;
  logic [SHIFT_BITS-1:0] shift_nxt;

  logic                  s2_valid_r;
  paa_flags_t            s2_flags_r;
  logic [MAG_BITS-1:0]   s2_ax_r, s2_ay_r;
  logic [SHIFT_BITS-1:0] s2_shift_r;

  always_comb begin
    mag_or    = s1_ax_r | s1_ay_r;
    shift_nxt = SHIFT_BITS'(NORM_TOP);
    for (int b = 0; b < MAG_BITS; b++) begin
      if (mag_or[b]) begin
        shift_nxt = SHIFT_BITS'(NORM_TOP - b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_flags_r <= s1_flags_r;
    s2_ax_r    <= s1_ax_r;
    s2_ay_r    <= s1_ay_r;
    s2_shift_r <= shift_nxt;
  end

  // stage 3: normalizing shift
  logic                        s3_valid_r;
  paa_flags_t                  s3_flags_r;
  logic signed [DATA_BITS-1:0] s3_x_r, s3_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_flags_r <= s2_flags_r;
    s3_x_r     <= signed'(DATA_BITS'(s2_ax_r) << s2_shift_r);
    s3_y_r     <= signed'(DATA_BITS'(s2_ay_r) << s2_shift_r);
  end

  // CORDIC vectoring pipeline
  logic                       cd_valid;
  paa_flags_t                 cd_flags;
  logic signed [ANG_BITS-1:0] cd_z;

  paa_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s3_valid_r),
    .flags_i (s3_flags_r),
    .x_i     (s3_x_r),
    .y_i     (s3_y_r),
    .valid_o (cd_valid),
    .flags_o (cd_flags),
    .z_o     (cd_z)
  );

  // stage 4: clamp, axis cases, scale to degrees
  logic [THETA_BITS-1:0] theta;
  logic [PROD_BITS-1:0]  prod_nxt;

  logic                 s4_valid_r;
  paa_flags_t           s4_flags_r;
  logic [PROD_BITS-1:0] s4_prod_r;

  always_comb begin
    if (cd_flags.ay_zero) begin
      theta = '0;
    end else if (cd_flags.ax_zero) begin
      theta = QUARTER_TURN;
    end else if (cd_z[ANG_BITS-1]) begin
      theta = '0;
    end else if (cd_z > signed'(ANG_BITS'(QUARTER_TURN))) begin
      theta = QUARTER_TURN;
    end else begin
      theta = THETA_BITS'(cd_z);
    end
    prod_nxt = {{SCALE_BITS{1'b0}}, theta} * {{THETA_BITS{1'b0}}, SCALE_V};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else begin
      s4_valid_r <= cd_valid;
    end
    s4_flags_r <= cd_flags;
    s4_prod_r  <= prod_nxt;
  end

  // stage 5: round, mirror into quadrant
  logic [PROD_BITS-1:0]        rnd;
  logic signed [OUT_BITS-1:0]  mag_deg, mir_deg, angle_nxt;

  logic                       out_valid_r;
  logic signed [OUT_BITS-1:0] out_angle_r;

  always_comb begin
    rnd       = s4_prod_r + ROUND_V;
    mag_deg   = signed'(OUT_BITS'(rnd[PROD_BITS-1:ROUND_SHIFT]));
    mir_deg   = s4_flags_r.neg_x ? HALF_TURN_FX - mag_deg : mag_deg;
    angle_nxt = s4_flags_r.neg_y ? -mir_deg : mir_deg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s4_valid_r;
    end
    out_angle_r <= angle_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_angle_deg = out_angle_r;

  `PAA_ASSERT_AFTER(a_beat_gives_result, in_accept, LATENCY, out_valid)
  `PAA_ASSERT_IMPLIES(a_result_has_beat, out_valid, $past(in_accept, LATENCY))
  `PAA_ASSERT_IMPLIES(a_angle_range, out_valid,
                      (out_angle_deg <= HALF_TURN_FX) && (out_angle_deg >= -HALF_TURN_FX))

endmodule
